// ----- design/tlbpa_pkg.sv -----
// ----------------------------------------------------------------------------
// tlbpa_pkg
// Types, codes and constants shared by the page allocator modules.
// ----------------------------------------------------------------------------
package tlbpa_pkg;

  localparam int unsigned DEF_PAGE_COUNT  = 65536;
  localparam int unsigned DEF_GROUP_PAGES = 1024;
  localparam int unsigned PN_W            = 20;
  localparam int unsigned CFG_W           = 32;
  localparam int unsigned USED_W          = 17;
  localparam logic [31:0] LFSR_MASK       = 32'h8020_0003;
  localparam int unsigned SEARCH_LIMIT    = 65536;
  localparam int unsigned SEARCH_CNT_W    = 17;

  localparam logic [0:0] CFG_PAGE_BASE = 1'b0;
  localparam logic [0:0] CFG_SEED      = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PAGES  = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       page_address;
    logic [1:0]        status;
    logic [USED_W-1:0] used_pages;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic start;      // latch item, clear counters
    logic clr_step;   // clear memory clearing pass
    logic lfsr_step;  // step search value, read group count
    logic scan_step;  // linear group scan step
    logic word_rd;    // read next map word of group
    logic commit_alloc;
    logic free_rd;    // read word of freed page
    logic commit_free;
    logic fail_full;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic total_full;
    logic grp_ok;        // group count read this cycle is not full
    logic limit_hit;
    logic scan_end;
    logic word_ok;       // word read is not full
    logic words_end;
    logic free_bad;
    logic free_bit_set;
  } dp_sts_t;

  function automatic logic [31:0] lfsr_next(input logic [31:0] v);
    lfsr_next = (v >> 1) ^ (v[0] ? LFSR_MASK : 32'd0);
  endfunction

endpackage

// ----- design/two_level_bitmap_page_allocator_core.sv -----
// ----------------------------------------------------------------------------
// two_level_bitmap_page_allocator_core
// Page allocator with a one bit per page used map and per-group counters.
// ----------------------------------------------------------------------------
// channel  direction  payload
// in_      input      kind, free_address
// out_     output     page_address, status, used_pages
// cfg_     input      page_base_number, search_seed
//
// After reset the used map is cleared, one word per cycle, while in_stall
// stays high. A free steps through S_FREE, S_FWAIT and S_OUT. An allocate
// steps through S_CHECK, then S_LFSR and S_GWAIT per search try, S_SCAN and
// S_SWAIT per group scanned, S_WORD and S_WWAIT per map word read, then
// S_OUT. The result waits in a register and holds off the next item until
// it is taken.
module two_level_bitmap_page_allocator_core
  import tlbpa_pkg::*;
#(
  parameter int unsigned PAGE_COUNT  = DEF_PAGE_COUNT,
  parameter int unsigned GROUP_PAGES = DEF_GROUP_PAGES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tlbpa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .kind(in_data.kind),
    .out_valid, .out_stall, .sts, .cmd
  );

  tlbpa_dp #(.PAGE_COUNT(PAGE_COUNT), .GROUP_PAGES(GROUP_PAGES)) u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wr_data,
    .in_item(in_data), .cmd, .sts, .out_item(out_data)
  );

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.used_pages <= USED_W'(PAGE_COUNT))
    else $error("used count out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.page_address == 32'd0)
    else $error("failed item carries address");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

endmodule

// ----- design/tlbpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlbpa_ctrl
// Sequencer for clearing pass, allocate search and free.
// ----------------------------------------------------------------------------
module tlbpa_ctrl
  import tlbpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      kind,
  output logic      out_valid,
  input  logic      out_stall,
  input  dp_sts_t   sts,
  output dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_LFSR, S_GWAIT, S_SCAN, S_SWAIT,
    S_WORD, S_WWAIT, S_FREE, S_FWAIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  assign in_stall  = !(state_r == S_IDLE) || out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          cmd.start = 1'b1;
          state_nxt = kind ? S_FREE : S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.total_full) begin
          cmd.fail_full = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_LFSR;
        end
      end
      S_LFSR: begin
        cmd.lfsr_step = 1'b1;
        state_nxt     = S_GWAIT;
      end
      S_GWAIT: begin
        if (sts.grp_ok) state_nxt = S_WORD;
        else if (sts.limit_hit) state_nxt = S_SCAN;
        else state_nxt = S_LFSR;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        state_nxt     = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.grp_ok) state_nxt = S_WORD;
        else if (sts.scan_end) begin
          cmd.fail_full = 1'b1;
          state_nxt     = S_OUT;
        end else state_nxt = S_SCAN;
      end
      S_WORD: begin
        cmd.word_rd = 1'b1;
        state_nxt   = S_WWAIT;
      end
      S_WWAIT: begin
        if (sts.word_ok) begin
          cmd.commit_alloc = 1'b1;
          state_nxt        = S_OUT;
        end else if (sts.words_end) begin
          cmd.fail_full = 1'b1;
          state_nxt     = S_OUT;
        end else state_nxt = S_WORD;
      end
      S_FREE: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FWAIT;
      end
      S_FWAIT: begin
        cmd.commit_free = 1'b1;
        state_nxt       = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/tlbpa_dp.sv -----
// ----------------------------------------------------------------------------
// tlbpa_dp
// Used map, group counters, search register and result register.
// ----------------------------------------------------------------------------
module tlbpa_dp
  import tlbpa_pkg::*;
#(
  parameter int unsigned PAGE_COUNT  = DEF_PAGE_COUNT,
  parameter int unsigned GROUP_PAGES = DEF_GROUP_PAGES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  in_item_t         in_item,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output out_item_t        out_item
);

  localparam int unsigned WORDS   = PAGE_COUNT / 32;
  localparam int unsigned GROUPS  = PAGE_COUNT / GROUP_PAGES;
  localparam int unsigned GWORDS  = GROUP_PAGES / 32;
  localparam int unsigned WA_W    = $clog2(WORDS);
  localparam int unsigned GA_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned GW_W    = (GWORDS > 1) ? $clog2(GWORDS) : 1;
  localparam int unsigned IDX_W   = $clog2(PAGE_COUNT);
  localparam int unsigned GCNT_W  = $clog2(GROUP_PAGES) + 1;
  localparam int unsigned GLOG    = $clog2(GROUP_PAGES);
  localparam int unsigned CLR_W   = WA_W + 1;

  logic [31:0]       map_mem [WORDS];
  logic [GCNT_W-1:0] grp_mem [GROUPS];

  logic [PN_W-1:0]   base_r;
  logic [31:0]       search_r;
  logic [USED_W-1:0] total_r;
  logic [CLR_W-1:0]  clr_r;
  logic [SEARCH_CNT_W-1:0] tries_r;
  logic [GA_W:0]     scan_r;
  logic [GA_W-1:0]   grp_r;
  logic [GW_W:0]     wcnt_r;
  logic [WA_W-1:0]   waddr_r;
  logic [31:0]       wdata_r;
  logic [GCNT_W-1:0] gdata_r;
  logic              grd_r, wrd_r;
  logic [31:0]       faddr_r;
  out_item_t         out_r;

  logic [31:0]       search_nxt;
  logic [GA_W-1:0]   grp_sel;
  logic [4:0]        bit_sel;
  logic [19:0]       f_idx;
  logic [IDX_W-1:0]  f_page;
  logic [WA_W-1:0]   f_word;
  logic [GA_W-1:0]   f_grp;
  logic              grp_wr;
  logic [GA_W-1:0]   grp_wa;
  logic [GCNT_W-1:0] grp_wd;
  logic              map_wr;
  logic [WA_W-1:0]   map_wa;
  logic [31:0]       map_wd;
  logic [GA_W-1:0]   grp_ra;
  logic [WA_W-1:0]   map_ra;
  logic [IDX_W-1:0]  a_idx;

  assign search_nxt = lfsr_next(search_r);
  assign f_idx      = faddr_r[31:12] - base_r;
  assign f_page     = f_idx[IDX_W-1:0];
  assign f_word     = f_page[IDX_W-1:5];
  assign f_grp      = GA_W'(f_page >> GLOG);
  assign a_idx      = {waddr_r, bit_sel};

  always_comb begin
    bit_sel = '0;
    for (int i = 31; i >= 0; i--) if (!wdata_r[i]) bit_sel = 5'(i);
  end

  always_comb begin
    grp_ra = grp_r;
    if (cmd.lfsr_step) grp_ra = GA_W'(search_nxt % GROUPS);
    else if (cmd.scan_step) grp_ra = scan_r[GA_W-1:0];
    map_ra = waddr_r;
    if (cmd.free_rd) map_ra = f_word;
  end

  assign grp_sel = grp_ra;

  always_comb begin
    map_wr = 1'b0;
    map_wa = waddr_r;
    map_wd = wdata_r | (32'd1 << bit_sel);
    grp_wr = 1'b0;
    grp_wa = grp_r;
    grp_wd = gdata_r + GCNT_W'(1);
    if (cmd.clr_step) begin
      map_wr = 1'b1;
      map_wa = clr_r[WA_W-1:0];
      map_wd = '0;
      grp_wr = 1'b1;
      grp_wa = GA_W'(clr_r[WA_W-1:0]);
      grp_wd = '0;
    end else if (cmd.commit_alloc) begin
      map_wr = 1'b1;
      grp_wr = 1'b1;
    end else if (cmd.commit_free && !sts.free_bad && sts.free_bit_set) begin
      map_wr = 1'b1;
      map_wa = f_word;
      map_wd = wdata_r & ~(32'd1 << f_page[4:0]);
      grp_wr = 1'b1;
      grp_wd = gdata_r - GCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (map_wr) map_mem[map_wa] <= map_wd;
    if (grp_wr) grp_mem[grp_wa] <= grp_wd;
    wdata_r <= map_mem[map_ra];
    gdata_r <= grp_mem[cmd.free_rd ? f_grp : grp_sel];
  end

  always_comb begin
    sts.clr_done     = (clr_r == CLR_W'(WORDS - 1)) ||
                       (clr_r >= CLR_W'(WORDS - 1));
    sts.total_full   = (total_r >= USED_W'(PAGE_COUNT));
    sts.grp_ok       = grd_r && (gdata_r < GCNT_W'(GROUP_PAGES));
    sts.limit_hit    = (tries_r >= SEARCH_CNT_W'(SEARCH_LIMIT));
    sts.scan_end     = (scan_r >= (GA_W+1)'(GROUPS));
    sts.word_ok      = wrd_r && (wdata_r != 32'hffff_ffff);
    sts.words_end    = (wcnt_r >= (GW_W+1)'(GWORDS));
    sts.free_bad     = (faddr_r[11:0] != 12'd0) ||
                       (f_idx >= 20'(PAGE_COUNT - 1) + 20'd1 && PAGE_COUNT < 1048576);
    sts.free_bit_set = wdata_r[f_page[4:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      search_r <= 32'd1;
      total_r  <= '0;
      clr_r    <= '0;
      out_r    <= '0;
      tries_r  <= '0;
      scan_r   <= '0;
      grp_r    <= '0;
      grd_r    <= 1'b0;
      wrd_r    <= 1'b0;
      wcnt_r   <= '0;
    end else begin
      grd_r <= 1'b0;
      wrd_r <= 1'b0;
      if (cfg_wr_en) begin
        if (cfg_index == CFG_PAGE_BASE) base_r <= cfg_wr_data[PN_W-1:0];
        else begin
          search_r <= (cfg_wr_data == 32'd0) ? 32'd1 : cfg_wr_data;
        end
      end
      if (cmd.clr_step) clr_r <= clr_r + CLR_W'(1);
      if (cmd.start) begin
        faddr_r <= in_item.free_address;
        tries_r <= '0;
        scan_r  <= '0;
        wcnt_r  <= '0;
      end
      if (cmd.lfsr_step) begin
        search_r <= search_nxt;
        tries_r  <= tries_r + SEARCH_CNT_W'(1);
        grp_r    <= grp_sel;
        waddr_r  <= WA_W'(grp_sel) * WA_W'(GWORDS);
        grd_r    <= 1'b1;
      end
      if (cmd.scan_step) begin
        scan_r  <= scan_r + (GA_W+1)'(1);
        grp_r   <= grp_sel;
        waddr_r <= WA_W'(grp_sel) * WA_W'(GWORDS);
        grd_r   <= 1'b1;
      end
      if (cmd.word_rd) begin
        wrd_r  <= 1'b1;
        wcnt_r <= wcnt_r + (GW_W+1)'(1);
      end
      if (wrd_r && !sts.word_ok) waddr_r <= waddr_r + WA_W'(1);
      if (cmd.fail_full) out_r <= '{32'd0, ST_NO_PAGES, total_r};
      if (cmd.commit_alloc) begin
        total_r <= total_r + USED_W'(1);
        out_r   <= '{{base_r + PN_W'(a_idx), 12'd0}, ST_OK, total_r + USED_W'(1)};
      end
      if (cmd.free_rd) grp_r <= f_grp;
      if (cmd.commit_free) begin
        if (sts.free_bad) out_r <= '{32'd0, ST_BAD_ADDR, total_r};
        else if (!sts.free_bit_set) out_r <= '{32'd0, ST_NOT_ALLOC, total_r};
        else begin
          total_r <= total_r - USED_W'(1);
          out_r   <= '{32'd0, ST_OK, total_r - USED_W'(1)};
        end
      end
    end
  end

  assign out_item = out_r;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap page allocator core. Items are
// queued by phase under several base and seed settings, driven with
// random gaps and stalls, and every result is checked against an
// in-bench allocator that tracks the used map, counters and search value.
// ----------------------------------------------------------------------------
module tb_top;
  import tlbpa_pkg::*;

  localparam int unsigned PAGES  = DEF_PAGE_COUNT;
  localparam int unsigned GPAGES = DEF_GROUP_PAGES;
  localparam int unsigned WORDS  = PAGES / 32;
  localparam int unsigned GROUPS = PAGES / GPAGES;
  localparam int unsigned GWORDS = GPAGES / 32;

  typedef enum logic [1:0] {SRC_RAW, SRC_LIVE, SRC_FREED} addr_src_e;
  typedef struct {
    in_item_t  item;
    addr_src_e src;
  } pend_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;

  two_level_bitmap_page_allocator_core dut (.*);

  // allocator shadow state
  logic [31:0]       map_words [WORDS];
  logic [10:0]       group_cnt [GROUPS];
  logic [USED_W-1:0] pages_used;
  logic [31:0]       lfsr_val;
  logic [PN_W-1:0]   base_pn;

  pend_t       pending_q [$];
  out_item_t   alloc_results_q [$];
  logic [31:0] live_pages_q [$];
  logic [31:0] last_freed;
  bit          in_busy;
  int          errors, n_alloc, n_free, n_stat [4];
  bit          calm;
  int          hold_left;
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  function automatic out_item_t predict_item(input in_item_t it);
    out_item_t   r;
    logic [31:0] idx, w;
    int          g;
    bit          found;
    r = '0;
    if (it.kind) begin
      idx = ((it.free_address >> 12) - base_pn) & 32'hfffff;
      if (it.free_address[11:0] != 0 || idx >= PAGES) r.status = ST_BAD_ADDR;
      else if (!map_words[idx/32][idx%32]) r.status = ST_NOT_ALLOC;
      else begin
        r.status = ST_OK;
        map_words[idx/32][idx%32] = 1'b0;
        if (group_cnt[idx/GPAGES] > 0) group_cnt[idx/GPAGES]--;
        if (pages_used > 0) pages_used--;
        foreach (live_pages_q[i]) if (live_pages_q[i] == it.free_address) begin
          live_pages_q.delete(i);
          break;
        end
        last_freed = it.free_address;
      end
    end else if (pages_used >= PAGES) begin
      r.status = ST_NO_PAGES;
    end else begin
      found = 0;
      g = 0;
      for (int n = 0; n < SEARCH_LIMIT; n++) begin
        lfsr_val = (lfsr_val >> 1) ^ (lfsr_val[0] ? 32'h8020_0003 : 32'd0);
        g = lfsr_val % GROUPS;
        if (group_cnt[g] < GPAGES) begin
          found = 1;
          break;
        end
      end
      if (!found) for (g = 0; g < GROUPS; g++) if (group_cnt[g] < GPAGES) break;
      for (w = g * GWORDS; w < (g + 1) * GWORDS; w++) if (map_words[w] != '1) break;
      for (int b = 0; b < 32; b++) if (!map_words[w][b]) begin
        map_words[w][b] = 1'b1;
        group_cnt[g]++;
        pages_used++;
        idx = w * 32 + b;
        r.page_address = {(base_pn + idx[PN_W-1:0]), 12'h000};
        r.status = ST_OK;
        live_pages_q.push_back(r.page_address);
        break;
      end
    end
    r.used_pages = pages_used;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    pend_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_busy) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 33)) begin
        p = pending_q.pop_front();
        if (p.src == SRC_LIVE && live_pages_q.size() > 0)
          p.item.free_address = live_pages_q[$urandom_range(live_pages_q.size() - 1)];
        else if (p.src == SRC_FREED)
          p.item.free_address = last_freed;
        in_data  <= p.item;
        in_valid <= 1'b1;
        in_busy  = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_alloc + n_free > 300) begin
      hold_done = 1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && $urandom_range(99) < 33;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && in_valid && !in_stall) begin
      if (in_data.kind) n_free++;
      else n_alloc++;
      alloc_results_q.push_back(predict_item(in_data));
      in_busy = 1'b0;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (alloc_results_q.size() == 0) begin
        report("unexpected item", out_data.page_address, 32'd0);
      end else begin
        e = alloc_results_q.pop_front();
        n_stat[e.status]++;
        if (out_data.page_address != e.page_address)
          report("page_address", out_data.page_address, e.page_address);
        if (out_data.status != e.status)
          report("status", 32'(out_data.status), 32'(e.status));
        if (out_data.used_pages != e.used_pages)
          report("used_pages", 32'(out_data.used_pages), 32'(e.used_pages));
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_PAGE_BASE) base_pn = val[PN_W-1:0];
    else lfsr_val = (val == 0) ? 32'd1 : val;
  endtask

  task automatic queue_item(input logic k, input logic [31:0] a, input addr_src_e s);
    pend_t p;
    p.item.kind = k;
    p.item.free_address = a;
    p.src = s;
    pending_q.push_back(p);
  endtask

  task automatic queue_random(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) queue_item(1'b0, $urandom, SRC_RAW);
      else if (r < 75) queue_item(1'b1, 0, SRC_LIVE);
      else if (r < 80) queue_item(1'b1, 0, SRC_FREED);
      else if (r < 90) queue_item(1'b1, {base_pn + PN_W'($urandom_range(PAGES + 63)), 12'h0},
                                   SRC_RAW);
      else queue_item(1'b1, $urandom, SRC_RAW);
    end
  endtask

  task automatic drain;
    while (pending_q.size() > 0 || in_busy || alloc_results_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    foreach (map_words[i]) map_words[i] = '0;
    foreach (group_cnt[i]) group_cnt[i] = '0;
    pages_used = '0;
    lfsr_val = 32'd1;
    base_pn = '0;
    last_freed = '0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_PAGE_BASE;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    in_busy = 1'b0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings
    repeat (4) queue_item(1'b0, 0, SRC_RAW);
    queue_item(1'b1, 0, SRC_LIVE);
    queue_item(1'b1, 0, SRC_FREED);
    queue_item(1'b1, 32'h0000_1001, SRC_RAW);
    queue_item(1'b1, {PN_W'(PAGES), 12'h0}, SRC_RAW);
    queue_item(1'b1, {PN_W'(PAGES - 1), 12'h0}, SRC_RAW);
    queue_item(1'b1, 32'hffff_ffff, SRC_RAW);
    queue_item(1'b1, 32'h0, SRC_RAW);
    queue_item(1'b0, 0, SRC_RAW);
    drain();

    // top base, all-ones seed: page numbers wrap
    write_reg(CFG_PAGE_BASE, 32'h000f_ffff);
    write_reg(CFG_SEED, 32'hffff_ffff);
    repeat (6) queue_item(1'b0, 0, SRC_RAW);
    queue_item(1'b1, 32'hffff_f000, SRC_RAW);
    queue_item(1'b1, 32'h0000_0000, SRC_RAW);
    queue_item(1'b1, 0, SRC_LIVE);
    queue_item(1'b1, {PN_W'(20'hfffff + PAGES), 12'h0}, SRC_RAW);
    queue_random(250);
    drain();

    // zero seed, random base
    write_reg(CFG_SEED, 32'h0);
    write_reg(CFG_PAGE_BASE, $urandom);
    calm = 1'b1;
    queue_random(300);
    drain();
    calm = 1'b0;

    write_reg(CFG_PAGE_BASE, 32'h0);
    write_reg(CFG_SEED, $urandom);
    queue_random(270);
    drain();

    write_reg(CFG_PAGE_BASE, 32'h000f_0000);
    write_reg(CFG_SEED, 32'h0000_0001);
    queue_random(250);
    drain();

    $display("covered %0d allocates and %0d frees over five base/seed settings",
             n_alloc, n_free);
    $display("results: %0d ok, %0d bad address, %0d not allocated, %0d pages held",
             n_stat[ST_OK], n_stat[ST_BAD_ADDR], n_stat[ST_NOT_ALLOC], pages_used);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tlbpa_pkg.sv
design/tlbpa_ctrl.sv
design/tlbpa_dp.sv
design/two_level_bitmap_page_allocator_core.sv
verif/tb_top.sv
